// ===== sv/sliding_window_anagram_match_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window anagram match block
// Implication checks on the rising clock edge, held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_TOP_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swam assertion failed");

// Next-cycle implication.
`define SWAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swam assertion failed");

`endif

// ===== sv/swam_pkg.sv =====
// ----------------------------------------------------------------------------
// swam_pkg
// Types and constants shared by the sliding window anagram match block.
// ----------------------------------------------------------------------------
`default_nettype none

package swam_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int ALPHABET    = 256;

	localparam int SYM_W   = 8;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W   = $clog2(MAX_PATTERN);
	localparam int ADDR_W  = $clog2(ALPHABET);
	localparam int DIFF_W  = LEN_W + 1;
	localparam int NDIFF_W = $clog2(ALPHABET + 1);

	typedef enum logic {
		FUNC_PATTERN = 1'b0,
		FUNC_TEXT    = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PAT_FULL = 2'd1,
		ST_PAT_LATE = 2'd2
	} status_t;

	// One read-modify-write on the count difference table
	typedef struct packed {
		logic              en;
		logic              up;
		logic [ADDR_W-1:0] addr;
	} cnt_op_t;

	typedef struct packed {
		status_t           status;
		logic [LEN_W-1:0]  pattern_length;
		logic              full;
	} win_info_t;

	typedef struct packed {
		logic             window_match;
		logic             found;
		status_t          status;
		logic [LEN_W-1:0] pattern_length;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/swam_if.sv =====
// ----------------------------------------------------------------------------
// swam_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface swam_in_if;
	logic                       valid;
	logic                       ready;
	swam_pkg::func_t            func;
	logic [swam_pkg::SYM_W-1:0] symbol;

	modport source (output valid, output func, output symbol, input ready);
	modport sink (input valid, input func, input symbol, output ready);
endinterface

interface swam_out_if;
	logic                         valid;
	logic                         ready;
	logic                         window_match;
	logic                         found;
	swam_pkg::status_t            status;
	logic [swam_pkg::LEN_W-1:0]   pattern_length;

	modport source (output valid, output window_match, output found, output status,
		output pattern_length, input ready);
	modport sink (input valid, input window_match, input found, input status,
		input pattern_length, output ready);
endinterface

`default_nettype wire

// ===== sv/sliding_window_anagram_match_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_match_top
// Reports whether the last pattern-length text bytes are a permutation of the
// loaded pattern, with a sticky found flag.
// ----------------------------------------------------------------------------
// An item is not taken while the one before it is still updating the table,
// and its result enters a two-entry output queue through the busy and fin
// registers. The pace is set by the single count difference table: it does
// one read-modify-write per cycle and a text byte in a full window needs two,
// one for the entering byte and one for the byte leaving the window. The table
// comes out of reset cleared through per-entry valid bits, so the block takes
// items as soon as reset is released.
`default_nettype none

module sliding_window_anagram_match_top (
	input  wire logic clk,
	input  wire logic arst_n,
	swam_in_if.sink   item,
	swam_out_if.source result
);
	import swam_pkg::*;

	`include "sliding_window_anagram_match_top_assert.svh"

	logic               accept;
	logic               push;
	logic               pop;
	logic               match;
	cnt_op_t            enter_op;
	cnt_op_t            leave_op;
	cnt_op_t            count_op;
	win_info_t          win_info;
	logic [NDIFF_W-1:0] differing;
	result_t            res_d;

	logic               busy_q;
	logic               fin_q;
	logic               found_q;
	logic [1:0]         occ_q;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	result_t            queue_q [2];

	swam_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (item.func),
		.symbol   (item.symbol),
		.enter_op (enter_op),
		.leave_op (leave_op),
		.info     (win_info)
	);

	swam_diff_table u_diff_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (count_op),
		.differing (differing)
	);

	always_comb begin
		// Hold off while the leaving byte update runs or the queue lacks room
		item.ready = !busy_q && ((occ_q + 2'(fin_q)) < 2'd2);
		accept     = item.valid && item.ready;
		count_op   = busy_q ? leave_op : enter_op;

		match        = win_info.full && (differing == '0);
		push         = fin_q;
		result.valid = (occ_q != 2'd0);
		pop          = result.valid && result.ready;

		res_d.window_match   = match;
		res_d.found          = found_q || match;
		res_d.status         = win_info.status;
		res_d.pattern_length = win_info.pattern_length;

		result.window_match   = queue_q[rd_ptr_q].window_match;
		result.found          = queue_q[rd_ptr_q].found;
		result.status         = queue_q[rd_ptr_q].status;
		result.pattern_length = queue_q[rd_ptr_q].pattern_length;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			fin_q    <= 1'b0;
			found_q  <= 1'b0;
			occ_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			busy_q <= accept;
			fin_q  <= busy_q;
			occ_q  <= occ_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
				found_q  <= found_q || match;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

	`SWAM_ASSERT_NEXT(a_accept_spacing, clk, arst_n, accept, !accept)
	`SWAM_ASSERT_IMPLY(a_queue_room, clk, arst_n, fin_q, occ_q < 2'd2)

endmodule

`default_nettype wire

// ===== sv/swam_window.sv =====
// ----------------------------------------------------------------------------
// swam_window
// Pattern length, window fill and ring pointer, plus the history memory that
// yields the byte leaving the window. Emits the count table operations.
// ----------------------------------------------------------------------------
`default_nettype none

module swam_window (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire swam_pkg::func_t            func,
	input  wire logic [swam_pkg::SYM_W-1:0] symbol,
	output swam_pkg::cnt_op_t               enter_op,
	output swam_pkg::cnt_op_t               leave_op,
	output swam_pkg::win_info_t             info
);
	import swam_pkg::*;

	`include "sliding_window_anagram_match_top_assert.svh"

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  seen_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              started_q;
	status_t           status_q;
	logic              leave_en_q;
	logic [ADDR_W-1:0] hist_rd_q;
	logic [ADDR_W-1:0] hist_mem [MAX_PATTERN];

	logic              is_text;
	logic [ADDR_W-1:0] sym_a;
	logic              has_pat;
	logic              full;
	logic              load_ok;
	logic              scan;
	status_t           status_d;
	logic [PTR_W-1:0]  ptr_next;

	always_comb begin
		is_text  = (func == FUNC_TEXT);
		// ALPHABET covers every byte value, so the reduction is a plain select
		sym_a    = symbol[ADDR_W-1:0];
		has_pat  = (len_q != '0);
		full     = (seen_q == len_q);
		load_ok  = !is_text && !started_q && (len_q != LEN_W'(MAX_PATTERN));
		scan     = is_text && has_pat;
		ptr_next = (LEN_W'(ptr_q) == len_q - LEN_W'(1)) ? '0 : ptr_q + PTR_W'(1);

		if (is_text) begin
			status_d = ST_OK;
		end else if (started_q) begin
			status_d = ST_PAT_LATE;
		end else if (len_q == LEN_W'(MAX_PATTERN)) begin
			status_d = ST_PAT_FULL;
		end else begin
			status_d = ST_OK;
		end

		// Pattern byte lowers the difference, entering text byte raises it
		enter_op.en   = accept && (load_ok || scan);
		enter_op.up   = is_text;
		enter_op.addr = sym_a;

		leave_op.en   = leave_en_q;
		leave_op.up   = 1'b0;
		leave_op.addr = hist_rd_q;

		info.status         = status_q;
		info.pattern_length = len_q;
		info.full           = has_pat && (seen_q == len_q);
	end

	// Read the leaving byte and store the entering one in the same slot
	always_ff @(posedge clk) begin
		if (accept && scan) begin
			hist_rd_q        <= hist_mem[ptr_q];
			hist_mem[ptr_q]  <= sym_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			seen_q     <= '0;
			ptr_q      <= '0;
			started_q  <= 1'b0;
			status_q   <= ST_OK;
			leave_en_q <= 1'b0;
		end else begin
			leave_en_q <= accept && scan && full;
			if (accept) begin
				status_q <= status_d;
				if (load_ok) begin
					len_q <= len_q + LEN_W'(1);
				end
				if (is_text) begin
					started_q <= 1'b1;
				end
				if (scan) begin
					if (!full) begin
						seen_q <= seen_q + LEN_W'(1);
					end
					ptr_q <= ptr_next;
				end
			end
		end
	end

	`SWAM_ASSERT_IMPLY(a_seen_le_len, clk, arst_n, 1'b1, seen_q <= len_q)
	`SWAM_ASSERT_IMPLY(a_ptr_in_window, clk, arst_n, len_q != '0, LEN_W'(ptr_q) < len_q)

endmodule

`default_nettype wire

// ===== sv/swam_diff_table.sv =====
// ----------------------------------------------------------------------------
// swam_diff_table
// Per-value difference of window count minus pattern count, one
// read-modify-write per cycle, with a running count of nonzero entries.
// ----------------------------------------------------------------------------
`default_nettype none

module swam_diff_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire swam_pkg::cnt_op_t            op,
	output logic [swam_pkg::NDIFF_W-1:0]      differing
);
	import swam_pkg::*;

	`include "sliding_window_anagram_match_top_assert.svh"

	logic [DIFF_W-1:0]  diff_mem [ALPHABET];
	logic [ALPHABET-1:0] valid_q;

	cnt_op_t            op_s1;
	logic [DIFF_W-1:0]  rd_s1;
	logic               vld_s1;

	logic               wr_en_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [DIFF_W-1:0]  wr_data_q;
	logic [NDIFF_W-1:0] differing_q;

	logic               fwd;
	logic [DIFF_W-1:0]  cur;
	logic [DIFF_W-1:0]  new_val;
	logic               was_diff;
	logic               is_diff;
	logic [NDIFF_W-1:0] differing_d;

	always_comb begin
		// A write at the edge of the read missed it: take it from the write register
		fwd      = wr_en_q && (wr_addr_q == op_s1.addr);
		cur      = fwd ? wr_data_q : (vld_s1 ? rd_s1 : '0);
		new_val  = op_s1.up ? cur + DIFF_W'(1) : cur - DIFF_W'(1);
		was_diff = (cur != '0);
		is_diff  = (new_val != '0);

		differing_d = differing_q;
		if (op_s1.en) begin
			if (was_diff && !is_diff) begin
				differing_d = differing_q - NDIFF_W'(1);
			end else if (!was_diff && is_diff) begin
				differing_d = differing_q + NDIFF_W'(1);
			end
		end
		differing = differing_d;
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			rd_s1 <= diff_mem[op.addr];
		end
		if (op_s1.en) begin
			diff_mem[op_s1.addr] <= new_val;
		end
		wr_addr_q <= op_s1.addr;
		wr_data_q <= new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			op_s1       <= '0;
			vld_s1      <= 1'b0;
			wr_en_q     <= 1'b0;
			differing_q <= '0;
		end else begin
			op_s1       <= op;
			vld_s1      <= valid_q[op.addr];
			wr_en_q     <= op_s1.en;
			differing_q <= differing_d;
			if (op_s1.en) begin
				valid_q[op_s1.addr] <= 1'b1;
			end
		end
	end

	// A nonzero entry must already be counted
	`SWAM_ASSERT_IMPLY(a_nonzero_counted, clk, arst_n, op_s1.en && cur != '0, differing_q != '0)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window anagram match block. It loads a
// full 64-byte pattern, overfills it, then streams text built mostly from
// shuffled copies of the pattern, mixed with near misses, noise, runs and late
// pattern bytes. A scoreboard predicts every result and compares it field by
// field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	import swam_pkg::*;

	localparam int TOTAL_ITEMS   = 1350;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int TAIL_CYCLES   = 16;
	localparam int POOL_SIZE     = 10;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;
	typedef enum int {
		TXT_PERM, TXT_REPEAT, TXT_NEAR_MISS, TXT_NOISE, TXT_PARTIAL, TXT_LATE_PAT, TXT_RUN
	} text_mode_t;

	logic clk;
	logic arst_n;

	swam_in_if  item_if ();
	swam_out_if result_if ();

	sliding_window_anagram_match_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// Predictor state
	logic [LEN_W-1:0] pat_count [ALPHABET];
	logic [LEN_W-1:0] win_count [ALPHABET];
	logic [SYM_W-1:0] text_hist [MAX_PATTERN];
	logic [PTR_W-1:0] hist_ptr;
	logic [LEN_W-1:0] pat_len;
	logic [LEN_W-1:0] text_seen;
	int               diff_values;
	logic             found_latched;
	logic             text_started;

	result_t          expected_results [$];

	// Stimulus bookkeeping
	logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
	logic [SYM_W-1:0] block_bytes [MAX_PATTERN];
	logic [SYM_W-1:0] pool [POOL_SIZE];
	int               burst_left;
	logic             tx_steady;
	logic             rx_hold_req;

	int items_sent;
	int text_items;
	int rejected_items;
	int results_seen;
	int window_hits;
	int mismatches;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Move one count entry and keep the number of differing values in step.
	function automatic void tally_change(logic in_window, logic [SYM_W-1:0] v, logic up);
		logic was_diff;
		logic is_diff;
		was_diff = win_count[v] != pat_count[v];
		if (in_window) begin
			if (up)
				win_count[v] = win_count[v] + 1'b1;
			else if (win_count[v] != '0)
				win_count[v] = win_count[v] - 1'b1;
		end else begin
			if (up)
				pat_count[v] = pat_count[v] + 1'b1;
			else if (pat_count[v] != '0)
				pat_count[v] = pat_count[v] - 1'b1;
		end
		is_diff = win_count[v] != pat_count[v];
		if (was_diff && !is_diff)
			diff_values--;
		else if (!was_diff && is_diff)
			diff_values++;
	endfunction

	function automatic result_t predict_window_result(func_t f, logic [SYM_W-1:0] s);
		result_t r;
		int      slot;
		r.status = ST_OK;
		if (f == FUNC_PATTERN) begin
			if (text_started)
				r.status = ST_PAT_LATE;
			else if (pat_len >= MAX_PATTERN)
				r.status = ST_PAT_FULL;
			else begin
				tally_change(1'b0, s, 1'b1);
				pat_len = pat_len + 1'b1;
			end
		end else begin
			text_started = 1'b1;
			if (pat_len != '0) begin
				slot = int'(hist_ptr) % int'(pat_len);
				// drop the leaving byte once the window is full
				if (text_seen >= pat_len)
					tally_change(1'b1, text_hist[slot], 1'b0);
				else
					text_seen = text_seen + 1'b1;
				tally_change(1'b1, s, 1'b1);
				text_hist[slot] = s;
				hist_ptr = PTR_W'((slot + 1) % int'(pat_len));
			end
		end
		r.window_match = (pat_len != '0) && (text_seen == pat_len) && (diff_values == 0);
		if (r.window_match)
			found_latched = 1'b1;
		r.found = found_latched;
		r.pattern_length = pat_len;
		return r;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Fill block_bytes with a random permutation of the pattern.
	function automatic void shuffle_pattern();
		int               j;
		logic [SYM_W-1:0] t;
		for (int i = 0; i < MAX_PATTERN; i++)
			block_bytes[i] = pattern_bytes[i];
		for (int i = MAX_PATTERN - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = block_bytes[i];
			block_bytes[i] = block_bytes[j];
			block_bytes[j] = t;
		end
	endfunction

	// Offer one item, hold it until the transfer, then predict its result.
	task automatic send_symbol(func_t f, logic [SYM_W-1:0] s);
		int      gap;
		result_t r;
		if (!tx_steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		item_if.valid  <= 1'b1;
		item_if.func   <= f;
		item_if.symbol <= s;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		r = predict_window_result(f, s);
		expected_results.push_back(r);
		items_sent++;
		if (f == FUNC_TEXT)
			text_items++;
		if (r.status != ST_OK)
			rejected_items++;
	endtask

	task automatic send_block(int count);
		for (int i = 0; i < count; i++)
			send_symbol(FUNC_TEXT, block_bytes[i]);
	endtask

	task automatic test_pattern_load();
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = SYM_W'($urandom_range(0, 255));
		pattern_bytes[0] = 8'h00;
		pattern_bytes[1] = 8'hFF;
		pattern_bytes[2] = 8'h55;
		pattern_bytes[3] = 8'hAA;
		// repeats from a small pool give counts above one
		for (int i = 4; i < MAX_PATTERN; i++)
			pattern_bytes[i] = pool[$urandom_range(0, POOL_SIZE - 1)];
		for (int i = 0; i < MAX_PATTERN; i++)
			send_symbol(FUNC_PATTERN, pattern_bytes[i]);
		// capacity reached: these are ignored
		send_symbol(FUNC_PATTERN, 8'hFF);
		send_symbol(FUNC_PATTERN, 8'h00);
		send_symbol(FUNC_PATTERN, SYM_W'($urandom_range(0, 255)));
	endtask

	task automatic test_first_window();
		shuffle_pattern();
		send_block(MAX_PATTERN);
		// a late pattern byte still reports the matching window
		send_symbol(FUNC_PATTERN, 8'h5A);
	endtask

	task automatic test_random_text(int stop_at);
		int         pick;
		int         len;
		text_mode_t mode;
		logic [SYM_W-1:0] v;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)      mode = TXT_PERM;
			else if (pick < 50) mode = TXT_REPEAT;
			else if (pick < 65) mode = TXT_NEAR_MISS;
			else if (pick < 80) mode = TXT_NOISE;
			else if (pick < 90) mode = TXT_PARTIAL;
			else if (pick < 95) mode = TXT_LATE_PAT;
			else                mode = TXT_RUN;
			case (mode)
				TXT_PERM: begin
					shuffle_pattern();
					send_block(MAX_PATTERN);
				end
				TXT_REPEAT: begin
					send_block(MAX_PATTERN);
				end
				TXT_NEAR_MISS: begin
					shuffle_pattern();
					block_bytes[$urandom_range(0, MAX_PATTERN - 1)] = SYM_W'($urandom_range(0, 255));
					send_block(MAX_PATTERN);
				end
				TXT_NOISE: begin
					len = $urandom_range(1, 24);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 1) != 0)
							v = pattern_bytes[$urandom_range(0, MAX_PATTERN - 1)];
						else
							v = SYM_W'($urandom_range(0, 255));
						send_symbol(FUNC_TEXT, v);
					end
				end
				TXT_PARTIAL: begin
					shuffle_pattern();
					send_block($urandom_range(1, MAX_PATTERN - 1));
				end
				TXT_LATE_PAT: begin
					len = $urandom_range(1, 3);
					for (int i = 0; i < len; i++)
						send_symbol(FUNC_PATTERN, SYM_W'($urandom_range(0, 255)));
				end
				default: begin
					pick = $urandom_range(0, 2);
					v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : SYM_W'($urandom_range(0, 255));
					len = $urandom_range(1, 70);
					for (int i = 0; i < len; i++)
						send_symbol(FUNC_TEXT, v);
				end
			endcase
		end
	endtask

	// Keep offering text while the result side is held off, so the block backs up.
	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		tx_steady = 1'b1;
		shuffle_pattern();
		send_block(40);
		tx_steady = 1'b0;
		while (rx_hold_req)
			@(posedge clk);
	endtask

	task automatic test_drain_pause();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing pending, match %0d found %0d status %0d len %0d",
					$time, result_if.window_match, result_if.found, result_if.status,
					result_if.pattern_length);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("window_match", want.window_match, result_if.window_match);
				check_field("found", want.found, result_if.found);
				check_field("status", want.status, result_if.status);
				check_field("pattern_length", want.pattern_length, result_if.pattern_length);
				if (want.window_match)
					window_hits++;
			end
			results_seen++;
		end
	end

	initial begin : result_sink
		int       run_left;
		int       phase;
		rx_mode_t mode;
		run_left = 0;
		phase = 0;
		mode = RX_OPEN;
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				result_if.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					run_left = $urandom_range(10, 80);
					phase = 0;
				end
				run_left--;
				phase++;
				case (mode)
					RX_OPEN:     result_if.ready <= 1'b1;
					RX_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: result_if.ready <= (phase % 3 == 0);
					default:     result_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results pending",
			$time, STALL_LIMIT, expected_results.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_if.valid  <= 1'b0;
		item_if.func   <= FUNC_PATTERN;
		item_if.symbol <= '0;
		for (int i = 0; i < ALPHABET; i++) begin
			pat_count[i] = '0;
			win_count[i] = '0;
		end
		for (int i = 0; i < MAX_PATTERN; i++)
			text_hist[i] = '0;
		hist_ptr = '0;
		pat_len = '0;
		text_seen = '0;
		diff_values = 0;
		found_latched = 1'b0;
		text_started = 1'b0;
		burst_left = 0;
		tx_steady = 1'b0;
		rx_hold_req = 1'b0;
		items_sent = 0;
		text_items = 0;
		rejected_items = 0;
		results_seen = 0;
		window_hits = 0;
		mismatches = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pattern_load();
		test_first_window();
		test_random_text(TOTAL_ITEMS / 2);
		test_backpressure();
		test_drain_pause();
		test_random_text(TOTAL_ITEMS);

		item_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			mismatches++;
		end

		$display("Sent %0d items: %0d text bytes, %0d ignored pattern bytes.",
			items_sent, text_items, rejected_items);
		$display("Checked %0d results, %0d of them matching windows, %0d mismatches.",
			results_seen, window_hits, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
